FILE: rtl/ttrail_pkg.sv
// ----------------------------------------------------------------------------
// ttrail_pkg
// Types and constants shared by the trail interpolator modules.
// ----------------------------------------------------------------------------
package ttrail_pkg;

    localparam int DEPTH   = 16;
    localparam int CNT_W   = $clog2(DEPTH);
    localparam int FRAC_W  = 18;
    localparam int LANES   = 9;
    localparam int LANE_W  = 4;

    typedef enum logic [1:0] {
        CMD_STORE = 2'd0,
        CMD_FILL  = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DIVGO,
        ST_DIV,
        ST_LERP,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [30:0]       time_ms;
        logic [2:0][31:0]  pos;
        logic [2:0][31:0]  vel;
        logic [2:0][15:0]  ang;
        logic [63:0]       attr;
    } t_slot;

    typedef struct packed {
        logic fill;
        logic shift;
        logic rotate;
    } t_cell_ctl;

endpackage

FILE: rtl/ttrail_cell.sv
// ----------------------------------------------------------------------------
// ttrail_cell
// One history slot; loads the new sample, its older or its newer neighbor.
// ----------------------------------------------------------------------------
module ttrail_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ttrail_pkg::t_cell_ctl i_ctl,
    input  ttrail_pkg::t_slot   i_sample,
    input  ttrail_pkg::t_slot   i_prev,
    input  ttrail_pkg::t_slot   i_next,
    output ttrail_pkg::t_slot   o_slot
);

    ttrail_pkg::t_slot r_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else if (i_ctl.fill) begin
            r_slot <= i_sample;
        end else if (i_ctl.shift) begin
            r_slot <= i_prev;
        end else if (i_ctl.rotate) begin
            r_slot <= i_next;
        end
    end

    assign o_slot = r_slot;

endmodule

FILE: rtl/ttrail_div.sv
// ----------------------------------------------------------------------------
// ttrail_div
// Serial divider for the saturated Q2.16 fraction, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module ttrail_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [30:0]                      i_num,
    input  logic signed [31:0]               i_den,
    output logic                             o_done,
    output logic [ttrail_pkg::FRAC_W-1:0]    o_frac
);

    localparam int FW = ttrail_pkg::FRAC_W;

    logic          r_busy;
    logic          r_done;
    logic [4:0]    r_cnt;
    logic [31:0]   r_rem;
    logic [31:0]   r_den;
    logic [FW-1:0] r_low;
    logic [FW-1:0] r_q;
    logic [31:0]   w_trial;

    assign w_trial = {r_rem[30:0], r_low[FW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_den <= i_den;
                if (i_den[31] || (i_den == 32'sd0)) begin
                    r_q    <= '0;
                    r_done <= 1'b1;
                end else if ({3'b0, i_num} >= {1'b0, i_den[30:0], 2'b0}) begin
                    r_q    <= '1;
                    r_done <= 1'b1;
                end else begin
                    r_rem  <= {3'b0, i_num[30:2]};
                    r_low  <= {i_num[1:0], 16'b0};
                    r_cnt  <= '0;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                if (w_trial >= r_den) begin
                    r_rem <= w_trial - r_den;
                    r_q   <= {r_q[FW-2:0], 1'b1};
                end else begin
                    r_rem <= w_trial;
                    r_q   <= {r_q[FW-2:0], 1'b0};
                end
                r_low <= {r_low[FW-2:0], 1'b0};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(FW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_frac = r_q;

endmodule

FILE: rtl/timestamped_trail_interpolator_core.sv
// ----------------------------------------------------------------------------
// timestamped_trail_interpolator_core
// Shift-register sample history with time query and linear interpolation, shorter-arc for the angles.
// ----------------------------------------------------------------------------
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+----------------------------------
//  input    | i_in_valid   | o_in_stall   | i_command, i_sample_time, sample
//  output   | o_out_valid  | i_out_stall  | o_out_*, o_bracket_found
//
// A store or fill transfer leaves the core idle and ready for the next one.
// A query stalls the input while the search rotates the cell chain once
// around, the serial divider runs and the shared multiplier works over nine
// lanes. Reset is synchronous and clears the history.
// A stalled result holds in the output register while the next transfer is
// taken; a second query then waits before its output stage.
module timestamped_trail_interpolator_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_command,
    input  logic [30:0]        i_sample_time,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_vel_x,
    input  logic signed [31:0] i_vel_y,
    input  logic signed [31:0] i_vel_z,
    input  logic [15:0]        i_ang_pitch,
    input  logic [15:0]        i_ang_yaw,
    input  logic [15:0]        i_ang_roll,
    input  logic [63:0]        i_attributes,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_out_pos_x,
    output logic signed [31:0] o_out_pos_y,
    output logic signed [31:0] o_out_pos_z,
    output logic signed [31:0] o_out_vel_x,
    output logic signed [31:0] o_out_vel_y,
    output logic signed [31:0] o_out_vel_z,
    output logic [15:0]        o_out_pitch,
    output logic [15:0]        o_out_yaw,
    output logic [15:0]        o_out_roll,
    output logic [63:0]        o_out_attributes,
    output logic               o_bracket_found
);

    localparam int D  = ttrail_pkg::DEPTH;
    localparam int CW = ttrail_pkg::CNT_W;
    localparam int FW = ttrail_pkg::FRAC_W;
    localparam int NL = ttrail_pkg::LANES;
    localparam int LW = ttrail_pkg::LANE_W;

    ttrail_pkg::t_state    r_state;
    ttrail_pkg::t_state    n_state;
    ttrail_pkg::t_cell_ctl w_ctl;
    ttrail_pkg::t_slot     w_sample;
    ttrail_pkg::t_slot     w_slot [D];

    logic              w_accept;
    logic              w_out_load;
    logic              w_div_start;
    logic              w_div_done;
    logic [FW-1:0]     w_frac;
    logic [30:0]       w_num;
    logic signed [31:0] w_den;

    logic [CW-1:0]     r_step;
    logic [30:0]       r_qtime;
    logic              r_hit;
    ttrail_pkg::t_slot r_near;
    ttrail_pkg::t_slot r_far;
    logic [FW-1:0]     r_frac;
    logic [LW-1:0]     r_lane;
    logic [1:0]        r_phase;
    logic signed [32:0] r_delta;
    logic signed [32:0] r_farv;
    logic signed [51:0] r_prod;
    logic [31:0]       r_res [NL];

    logic              r_out_valid;
    logic [31:0]       r_o_res [NL];
    logic [63:0]       r_o_attr;
    logic              r_o_found;

    logic [31:0]        w_near_sel;
    logic [31:0]        w_far_sel;
    logic               w_is_ang;
    logic signed [17:0] w_ang_d;
    logic signed [17:0] w_ang_dw;
    logic signed [52:0] w_round;
    logic signed [37:0] w_sum;
    logic [31:0]        w_lane_res;

    assign w_sample = '{time_ms: i_sample_time,
                        pos: {i_pos_z, i_pos_y, i_pos_x},
                        vel: {i_vel_z, i_vel_y, i_vel_x},
                        ang: {i_ang_roll, i_ang_yaw, i_ang_pitch},
                        attr: i_attributes};

    genvar s;
    generate
        for (s = 0; s < D; s++) begin : g_cell
            localparam int NX = (s + 1) % D;
            if (s == 0) begin : g_head
                ttrail_cell u_cell (
                    .i_clk    (i_clk),
                    .i_rst_n  (i_rst_n),
                    .i_ctl    (w_ctl),
                    .i_sample (w_sample),
                    .i_prev   (w_sample),
                    .i_next   (w_slot[NX]),
                    .o_slot   (w_slot[s])
                );
            end else begin : g_body
                ttrail_cell u_cell (
                    .i_clk    (i_clk),
                    .i_rst_n  (i_rst_n),
                    .i_ctl    (w_ctl),
                    .i_sample (w_sample),
                    .i_prev   (w_slot[s-1]),
                    .i_next   (w_slot[NX]),
                    .o_slot   (w_slot[s])
                );
            end
        end
    endgenerate

    assign w_num = r_qtime - r_far.time_ms;
    assign w_den = r_hit ? ($signed({1'b0, r_near.time_ms}) - $signed({1'b0, r_far.time_ms}))
                         : 32'sd0;

    ttrail_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_frac  (w_frac)
    );

    always_comb begin
        w_near_sel = '0;
        w_far_sel  = '0;
        w_is_ang   = 1'b0;
        case (r_lane)
            4'd0, 4'd1, 4'd2: begin
                w_near_sel = r_near.pos[r_lane[1:0]];
                w_far_sel  = r_far.pos[r_lane[1:0]];
            end
            4'd3: begin
                w_near_sel = r_near.vel[0];
                w_far_sel  = r_far.vel[0];
            end
            4'd4: begin
                w_near_sel = r_near.vel[1];
                w_far_sel  = r_far.vel[1];
            end
            4'd5: begin
                w_near_sel = r_near.vel[2];
                w_far_sel  = r_far.vel[2];
            end
            4'd6: begin
                w_near_sel = {16'b0, r_near.ang[0]};
                w_far_sel  = {16'b0, r_far.ang[0]};
                w_is_ang   = 1'b1;
            end
            4'd7: begin
                w_near_sel = {16'b0, r_near.ang[1]};
                w_far_sel  = {16'b0, r_far.ang[1]};
                w_is_ang   = 1'b1;
            end
            4'd8: begin
                w_near_sel = {16'b0, r_near.ang[2]};
                w_far_sel  = {16'b0, r_far.ang[2]};
                w_is_ang   = 1'b1;
            end
            default: begin
                w_near_sel = '0;
                w_far_sel  = '0;
            end
        endcase
    end

    always_comb begin
        w_ang_d  = $signed({2'b0, w_near_sel[15:0]}) - $signed({2'b0, w_far_sel[15:0]});
        w_ang_dw = w_ang_d;
        if (w_ang_d > 18'sd32768) begin
            w_ang_dw = w_ang_d - 18'sd65536;
        end else if (w_ang_d < -18'sd32768) begin
            w_ang_dw = w_ang_d + 18'sd65536;
        end
    end

    always_comb begin
        w_round = {r_prod[51], r_prod} + 53'sd32768;
        w_sum   = {{5{r_farv[32]}}, r_farv} + {w_round[52], w_round[52:16]};
        if (w_is_ang) begin
            w_lane_res = {16'b0, w_sum[15:0]};
        end else if (w_sum > 38'sd2147483647) begin
            w_lane_res = 32'h7FFF_FFFF;
        end else if (w_sum < -38'sd2147483648) begin
            w_lane_res = 32'h8000_0000;
        end else begin
            w_lane_res = w_sum[31:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ttrail_pkg::ST_IDLE: begin
                if (w_accept && (i_command == ttrail_pkg::CMD_QUERY)) begin
                    n_state = ttrail_pkg::ST_SEARCH;
                end
            end
            ttrail_pkg::ST_SEARCH: begin
                if (r_step == CW'(D - 1)) begin
                    n_state = ttrail_pkg::ST_DIVGO;
                end
            end
            ttrail_pkg::ST_DIVGO: n_state = ttrail_pkg::ST_DIV;
            ttrail_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_state = ttrail_pkg::ST_LERP;
                end
            end
            ttrail_pkg::ST_LERP: begin
                if ((r_phase == 2'd2) && (r_lane == LW'(NL - 1))) begin
                    n_state = ttrail_pkg::ST_OUT;
                end
            end
            ttrail_pkg::ST_OUT: begin
                if (w_out_load) begin
                    n_state = ttrail_pkg::ST_IDLE;
                end
            end
            default: n_state = ttrail_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall  = (r_state != ttrail_pkg::ST_IDLE);
        w_accept    = i_in_valid && (r_state == ttrail_pkg::ST_IDLE);
        w_ctl.fill   = w_accept && (i_command == ttrail_pkg::CMD_FILL);
        w_ctl.shift  = w_accept && (i_command == ttrail_pkg::CMD_STORE);
        w_ctl.rotate = (r_state == ttrail_pkg::ST_SEARCH);
        w_div_start = (r_state == ttrail_pkg::ST_DIVGO);
        w_out_load  = (r_state == ttrail_pkg::ST_OUT) && (!r_out_valid || !i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ttrail_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_qtime <= i_sample_time;
            r_hit   <= 1'b0;
            r_step  <= '0;
        end
        if (r_state == ttrail_pkg::ST_SEARCH) begin
            r_step <= r_step + CW'(1);
            if (!r_hit && (r_step != CW'(D - 1)) && (w_slot[1].time_ms <= r_qtime)) begin
                r_hit  <= 1'b1;
                r_near <= w_slot[0];
                r_far  <= w_slot[1];
            end else if (r_step == '0) begin
                r_near <= w_slot[0];
                r_far  <= w_slot[0];
            end
        end
        if (w_div_done) begin
            r_frac  <= w_frac;
            r_lane  <= '0;
            r_phase <= '0;
        end
        if (r_state == ttrail_pkg::ST_LERP) begin
            case (r_phase)
                2'd0: begin
                    if (w_is_ang) begin
                        r_delta <= 33'(w_ang_dw);
                        r_farv  <= $signed({17'b0, w_far_sel[15:0]});
                    end else begin
                        r_delta <= $signed({w_near_sel[31], w_near_sel})
                                 - $signed({w_far_sel[31], w_far_sel});
                        r_farv  <= $signed({w_far_sel[31], w_far_sel});
                    end
                    r_phase <= 2'd1;
                end
                2'd1: begin
                    r_prod  <= r_delta * $signed({1'b0, r_frac});
                    r_phase <= 2'd2;
                end
                2'd2: begin
                    r_res[r_lane] <= w_lane_res;
                    r_lane        <= r_lane + LW'(1);
                    r_phase       <= 2'd0;
                end
                default: r_phase <= 2'd0;
            endcase
        end
        if (w_out_load) begin
            r_o_res   <= r_res;
            r_o_attr  <= r_near.attr;
            r_o_found <= r_hit;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_pos_x      = $signed(r_o_res[0]);
    assign o_out_pos_y      = $signed(r_o_res[1]);
    assign o_out_pos_z      = $signed(r_o_res[2]);
    assign o_out_vel_x      = $signed(r_o_res[3]);
    assign o_out_vel_y      = $signed(r_o_res[4]);
    assign o_out_vel_z      = $signed(r_o_res[5]);
    assign o_out_pitch      = r_o_res[6][15:0];
    assign o_out_yaw        = r_o_res[7][15:0];
    assign o_out_roll       = r_o_res[8][15:0];
    assign o_out_attributes = r_o_attr;
    assign o_bracket_found  = r_o_found;

endmodule

FILE: sim/timestamped_trail_interpolator_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// timestamped_trail_interpolator_core_tb
// Drives store, fill, query and unused commands into the trail interpolator,
// predicts every query result from a private copy of the sample history and
// compares each output transfer field by field, under several idle and stall patterns.
// ----------------------------------------------------------------------------
module timestamped_trail_interpolator_core_tb;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [30:0]       tms;
        logic [2:0][31:0]  pos;
        logic [2:0][31:0]  vel;
        logic [2:0][15:0]  ang;
        logic [63:0]       attr;
    } t_item;

    typedef struct packed {
        logic [2:0][31:0]  pos;
        logic [2:0][31:0]  vel;
        logic [2:0][15:0]  ang;
        logic [63:0]       attr;
        logic              found;
    } t_lerp;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_stall = 1'b0;
    logic in_stall, out_valid;
    t_item cur = '0;
    logic signed [31:0] o_px, o_py, o_pz, o_vx, o_vy, o_vz;
    logic [15:0] o_pitch, o_yaw, o_roll;
    logic [63:0] o_attr;
    logic o_found;

    t_item pending_items[$];
    t_lerp expected_lerps[$];
    ttrail_pkg::t_slot trail[ttrail_pkg::DEPTH];
    int send_idle_pct = 0;
    int stall_pct = 0;
    int mismatches = 0;
    int cycles = 0;
    bit stim_done = 1'b0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    timestamped_trail_interpolator_core DUT (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_command(cur.cmd), .i_sample_time(cur.tms),
        .i_pos_x(cur.pos[0]), .i_pos_y(cur.pos[1]), .i_pos_z(cur.pos[2]),
        .i_vel_x(cur.vel[0]), .i_vel_y(cur.vel[1]), .i_vel_z(cur.vel[2]),
        .i_ang_pitch(cur.ang[0]), .i_ang_yaw(cur.ang[1]), .i_ang_roll(cur.ang[2]),
        .i_attributes(cur.attr),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_out_pos_x(o_px), .o_out_pos_y(o_py), .o_out_pos_z(o_pz),
        .o_out_vel_x(o_vx), .o_out_vel_y(o_vy), .o_out_vel_z(o_vz),
        .o_out_pitch(o_pitch), .o_out_yaw(o_yaw), .o_out_roll(o_roll),
        .o_out_attributes(o_attr), .o_bracket_found(o_found)
    );

    function automatic longint scale_frac(longint d, longint f);
        longint p;
        p = d * f + 32768;
        if (p >= 0) return p / 65536;
        return -((-p + 65535) / 65536);
    endfunction

    function automatic logic [31:0] lerp_coord(logic [31:0] a, logic [31:0] b, longint f);
        longint r;
        r = longint'($signed(a)) + scale_frac(longint'($signed(b)) - longint'($signed(a)), f);
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

    function automatic logic [15:0] lerp_turn(logic [15:0] a, logic [15:0] b, longint f);
        longint d, r;
        d = longint'(b) - longint'(a);
        if (d > 32768) d -= 65536;
        if (d < -32768) d += 65536;
        r = longint'(a) + scale_frac(d, f);
        return r[15:0];
    endfunction

    task automatic apply_to_trail(t_item it);
        ttrail_pkg::t_slot s;
        t_lerp e;
        int fi, ni;
        longint num, den, q, f;
        s = {it.tms, it.pos, it.vel, it.ang, it.attr};
        case (ttrail_pkg::t_cmd'(it.cmd))
            ttrail_pkg::CMD_STORE: begin
                for (int k = ttrail_pkg::DEPTH - 1; k > 0; k--) trail[k] = trail[k - 1];
                trail[0] = s;
            end
            ttrail_pkg::CMD_FILL: begin
                for (int k = 0; k < ttrail_pkg::DEPTH; k++) trail[k] = s;
            end
            ttrail_pkg::CMD_QUERY: begin
                fi = 0;
                ni = 0;
                f = 0;
                e.found = 1'b0;
                for (int k = 1; k < ttrail_pkg::DEPTH; k++) begin
                    if (!e.found && trail[k].time_ms <= it.tms) begin
                        fi = k;
                        ni = k - 1;
                        e.found = 1'b1;
                    end
                end
                if (e.found) begin
                    num = longint'(it.tms) - longint'(trail[fi].time_ms);
                    den = longint'(trail[ni].time_ms) - longint'(trail[fi].time_ms);
                    if (den > 0) begin
                        q = (num * 65536) / den;
                        f = (q > 'h3FFFF) ? 'h3FFFF : q;
                    end
                end
                for (int k = 0; k < 3; k++) begin
                    e.pos[k] = lerp_coord(trail[fi].pos[k], trail[ni].pos[k], f);
                    e.vel[k] = lerp_coord(trail[fi].vel[k], trail[ni].vel[k], f);
                    e.ang[k] = lerp_turn(trail[fi].ang[k], trail[ni].ang[k], f);
                end
                e.attr = trail[ni].attr;
                expected_lerps.push_back(e);
            end
            default: ;
        endcase
    endtask

    function automatic t_item rand_item(logic [1:0] c, logic [30:0] t);
        t_item it;
        it.cmd = c;
        it.tms = t;
        for (int k = 0; k < 3; k++) begin
            it.pos[k] = $urandom;
            it.vel[k] = $urandom;
            it.ang[k] = 16'($urandom);
            if ($urandom_range(0, 3) == 0) begin
                it.pos[k] = {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'h0} - 32'($urandom_range(0, 1));
                it.ang[k] = 16'($urandom_range(0, 3) * 16384);
            end
        end
        it.attr = {$urandom, $urandom};
        return it;
    endfunction

    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall) begin
            apply_to_trail(cur);
        end
        if (!rst_n || (in_valid && in_stall)) begin
        end else if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            in_valid <= 1'b1;
            cur <= pending_items.pop_front();
        end else begin
            in_valid <= 1'b0;
        end
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk) begin
        t_lerp e;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_lerps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transfer");
            end else begin
                e = expected_lerps.pop_front();
                if (e.pos[0] !== o_px || e.pos[1] !== o_py || e.pos[2] !== o_pz ||
                    e.vel[0] !== o_vx || e.vel[1] !== o_vy || e.vel[2] !== o_vz ||
                    e.ang[0] !== o_pitch || e.ang[1] !== o_yaw || e.ang[2] !== o_roll ||
                    e.attr !== o_attr || e.found !== o_found) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch exp pos %h vel %h ang %h attr %h found %b",
                                 e.pos, e.vel, e.ang, e.attr, e.found);
                        $display("         got pos %h%h%h vel %h%h%h ang %h%h%h attr %h found %b",
                                 o_pz, o_py, o_px, o_vz, o_vy, o_vx,
                                 o_roll, o_yaw, o_pitch, o_attr, o_found);
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > 400000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        logic [30:0] base, t;
        int n;
        for (int k = 0; k < ttrail_pkg::DEPTH; k++) trail[k] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        // Directed: empty history, extremes, equal times, extrapolation.
        pending_items.push_back(rand_item(ttrail_pkg::CMD_QUERY, 31'd0));
        pending_items.push_back(rand_item(ttrail_pkg::CMD_QUERY, 31'h7FFFFFFF));
        pending_items.push_back(rand_item(ttrail_pkg::CMD_FILL, 31'd100));
        pending_items.push_back(rand_item(ttrail_pkg::CMD_QUERY, 31'd100));
        pending_items.push_back(rand_item(ttrail_pkg::CMD_QUERY, 31'd50));
        pending_items.push_back(rand_item(ttrail_pkg::CMD_STORE, 31'd200));
        pending_items.push_back(rand_item(ttrail_pkg::CMD_QUERY, 31'd150));
        pending_items.push_back(rand_item(ttrail_pkg::CMD_QUERY, 31'h7FFFFFFF));
        pending_items.push_back(rand_item(ttrail_pkg::CMD_STORE, 31'd150));
        pending_items.push_back(rand_item(ttrail_pkg::CMD_QUERY, 31'd175));
        pending_items.push_back(rand_item(ttrail_pkg::CMD_NOP, 31'h7FFFFFFF));
        pending_items.push_back(rand_item(ttrail_pkg::CMD_STORE, 31'h7FFFFFFF));
        pending_items.push_back(rand_item(ttrail_pkg::CMD_QUERY, 31'h7FFFFFFE));
        pending_items.push_back(rand_item(ttrail_pkg::CMD_QUERY, 31'd0));
        pending_items.push_back(rand_item(ttrail_pkg::CMD_FILL, 31'd0));
        pending_items.push_back(rand_item(ttrail_pkg::CMD_QUERY, 31'd0));
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 60 : 23) : 0;
            stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 60 : 23) : 0;
            n = 0;
            while (n < 235) begin
                if ($urandom_range(0, 19) == 0) begin
                    base = $urandom_range(0, 1) ? 31'($urandom) : 31'($urandom_range(0, 5000));
                    pending_items.push_back(rand_item(ttrail_pkg::CMD_FILL, base));
                end
                base = pending_items.size() ? 31'($urandom_range(0, 100000)) : 31'd0;
                t = base;
                repeat ($urandom_range(1, 6)) begin
                    if ($urandom_range(0, 7) == 0) t = 31'($urandom);
                    else t = t + 31'($urandom_range(0, 40));
                    pending_items.push_back(rand_item(ttrail_pkg::CMD_STORE, t));
                    n++;
                end
                repeat ($urandom_range(1, 3)) begin
                    pending_items.push_back(rand_item($urandom_range(0, 15) == 0
                        ? ttrail_pkg::CMD_NOP : ttrail_pkg::CMD_QUERY,
                        $urandom_range(0, 3) == 0 ? 31'($urandom)
                        : t - 31'($urandom_range(0, 200)) + 31'($urandom_range(0, 60))));
                    n++;
                end
            end
            while (pending_items.size() > 0 || in_valid) @(posedge clk);
        end
        while (expected_lerps.size() > 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatches == 0 && expected_lerps.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
